[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the top-level RTL file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is asserted
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	`ASSERT_PROP(lbl, clk, rst_n, !(expr), msg)

`endif

[sv/ipr_pkg.sv]
// ---------------------------------------------------------------------------
// ipr_pkg
// Shared constants and command/status types of the address range table.
// ---------------------------------------------------------------------------
package ipr_pkg;

	// Default table depth
	localparam int TABLE_ENTRIES_DFLT = 256;

	// Result status codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_HIT       = 3'd3;
	localparam logic [2:0] ST_MISS      = 3'd4;

	// Operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // capture the item, restart the scan
		logic issue;   // read the next stored entry
		logic finish;  // resolve the item and emit its result
	} ipr_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic empty;   // no entry stored
		logic last;    // current read address is the last stored entry
	} ipr_sts_t;

endpackage

[sv/ipr_ctrl.sv]
// ---------------------------------------------------------------------------
// ipr_ctrl
// Sequencer: accepts an item, drives the scan over the stored entries,
// waits for the last compare and triggers the result.
// ---------------------------------------------------------------------------
module ipr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ipr_pkg::ipr_sts_t sts,
	output ipr_pkg::ipr_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.issue  = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = sts.empty ? S_DRAIN : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

[sv/ipr_dpath.sv]
// ---------------------------------------------------------------------------
// ipr_dpath
// Range stores, scan address counter, compare stage, entry count and
// result registers.
// ---------------------------------------------------------------------------
module ipr_dpath #(
	parameter int TABLE_ENTRIES = ipr_pkg::TABLE_ENTRIES_DFLT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ipr_pkg::ipr_cmd_t cmd,
	output ipr_pkg::ipr_sts_t sts,
	input  logic              op,
	input  logic [31:0]       range_start,
	input  logic [31:0]       range_end,
	input  logic [31:0]       lookup_key,
	output logic              done,
	output logic [2:0]        status,
	output logic [7:0]        entry_index
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	// Range stores
	logic [31:0] start_mem [TABLE_ENTRIES];
	logic [31:0] end_mem   [TABLE_ENTRIES];

	// Captured item
	logic              op_q;
	logic [31:0]       s_q;
	logic [31:0]       e_q;
	logic [31:0]       key_q;

	// Scan state
	logic [IDX_W-1:0]  addr_q;
	logic [CNT_W-1:0]  count_q;
	logic              valid_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [31:0]       start_rd_s1;
	logic [31:0]       end_rd_s1;

	// Running results
	logic              found_q;
	logic              dup_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [31:0]       best_start_q;
	logic [31:0]       best_end_q;

	// Output registers
	logic              done_q;
	logic [2:0]        status_q;
	logic [7:0]        index_q;

	logic              full;
	logic              wr_en;
	logic              cand_le;
	logic              cand_better;
	logic              cand_dup;
	logic              take_best;

	assign full        = (count_q >= CNT_W'(TABLE_ENTRIES));
	assign wr_en       = cmd.finish && (op_q == ipr_pkg::OP_INSERT) && !dup_q && !full;
	assign cand_le     = (start_rd_s1 <= key_q);
	assign cand_better = !found_q || (start_rd_s1 > best_start_q);
	assign cand_dup    = (start_rd_s1 == s_q);
	assign take_best   = valid_s1 && (op_q == ipr_pkg::OP_LOOKUP) && cand_le && cand_better;

	assign sts.empty = (count_q == '0);
	assign sts.last  = ((CNT_W'(addr_q) + CNT_W'(1)) == count_q);

	// Store write and registered scan read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_mem[count_q[IDX_W-1:0]] <= s_q;
			end_mem[count_q[IDX_W-1:0]]   <= e_q;
		end
		if (cmd.issue) begin
			start_rd_s1 <= start_mem[addr_q];
			end_rd_s1   <= end_mem[addr_q];
		end
	end

	// Capture the item and track the best candidate
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			s_q   <= range_start;
			e_q   <= range_end;
			key_q <= lookup_key;
		end
		idx_s1 <= addr_q;
		if (take_best) begin
			best_idx_q   <= idx_s1;
			best_start_q <= start_rd_s1;
			best_end_q   <= end_rd_s1;
		end
	end

	// Scan control, entry count and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
			found_q  <= 1'b0;
			dup_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			done_q   <= cmd.finish;
			if (cmd.load) begin
				addr_q  <= '0;
				found_q <= 1'b0;
				dup_q   <= 1'b0;
			end else begin
				if (cmd.issue) begin
					addr_q <= addr_q + IDX_W'(1);
				end
				if (take_best) begin
					found_q <= 1'b1;
				end
				if (valid_s1 && (op_q == ipr_pkg::OP_INSERT) && cand_dup) begin
					dup_q <= 1'b1;
				end
			end
			if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Resolve the result
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (op_q == ipr_pkg::OP_INSERT) begin
				if (dup_q) begin
					status_q <= ipr_pkg::ST_DUPLICATE;
					index_q  <= '0;
				end else if (full) begin
					status_q <= ipr_pkg::ST_FULL;
					index_q  <= '0;
				end else begin
					status_q <= ipr_pkg::ST_INSERTED;
					index_q  <= 8'(count_q);
				end
			end else begin
				if (found_q && (key_q <= best_end_q)) begin
					status_q <= ipr_pkg::ST_HIT;
					index_q  <= 8'(best_idx_q);
				end else begin
					status_q <= ipr_pkg::ST_MISS;
					index_q  <= '0;
				end
			end
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign entry_index = index_q;

endmodule

[sv/ip_range_table_lookup_top.sv]
// ---------------------------------------------------------------------------
// ip_range_table_lookup_top
// Table of IPv4 address ranges with insert and longest-start lookup.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive op, range_start, range_end and lookup_key with
//   start high; the item is taken at the rising edge where start is high and
//   busy is low. An insert (op 0) appends a range unless its start is already
//   stored or the table is full; a lookup (op 1) finds the entry with the
//   greatest start not above the key and reports a hit when the key is
//   within its end.
//   Result channel: status and entry_index are valid for the single cycle in
//   which done is high; the receiver must take them then, it cannot stall.
//   Timing: after the accept edge the sequencer scans every stored entry
//   through the single read port of the range stores, one read per entry,
//   then drains the compare stage and resolves the result. done rises and
//   busy falls in the same cycle, so no new item is taken before done.
//   Reset: arst_n empties the table and returns the sequencer to idle; the
//   stores themselves are not cleared, unwritten entries are never read.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ip_range_table_lookup_top #(
	parameter int TABLE_ENTRIES = ipr_pkg::TABLE_ENTRIES_DFLT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [31:0] range_start,
	input  logic [31:0] range_end,
	input  logic [31:0] lookup_key,
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  entry_index
);

	ipr_pkg::ipr_cmd_t cmd;
	ipr_pkg::ipr_sts_t sts;

	// Sequencer
	ipr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Stores and scan datapath
	ipr_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.range_start (range_start),
		.range_end   (range_end),
		.lookup_key  (lookup_key),
		.done        (done),
		.status      (status),
		.entry_index (entry_index)
	);

	// Check the transfer sequencing and result codes
	`ASSERT_PROP(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "accepted item did not raise busy")
	`ASSERT_PROP(a_done_after_busy, clk, arst_n, done |-> $past(busy), "result without an item in work")
	`ASSERT_PROP(a_done_pulse, clk, arst_n, done |=> !done, "result strobe longer than one cycle")
	`ASSERT_NEVER(a_status_code, clk, arst_n, done && !(status == ipr_pkg::ST_INSERTED || status == ipr_pkg::ST_DUPLICATE || status == ipr_pkg::ST_FULL || status == ipr_pkg::ST_HIT || status == ipr_pkg::ST_MISS), "undefined status code")

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IPv4 address range table.
// Inserts and lookups are sent on the command channel in bursts with random
// gaps. A predictor in the bench holds its own copy of the table and works
// out the status and index of every transfer. The monitor compares each done
// strobe with the oldest outstanding prediction. Directed items cover the
// empty table, address extremes, duplicate starts and inverted ranges. A
// random phase then fills the table to its last entry, and a final phase
// works the full table.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int DEPTH          = ipr_pkg::TABLE_ENTRIES_DFLT;
	localparam int WATCHDOG_LIMIT = 10 * (DEPTH + 8);
	localparam int FULL_ITEMS     = 800;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] index;
	} outcome_t;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic        op          = ipr_pkg::OP_INSERT;
	logic [31:0] range_start = '0;
	logic [31:0] range_end   = '0;
	logic [31:0] lookup_key  = '0;
	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic [7:0]  entry_index;

	// Shadow copy of the range table
	logic [31:0] tbl_start [DEPTH];
	logic [31:0] tbl_end   [DEPTH];
	int          tbl_count = 0;

	outcome_t    pending_results[$];
	int          err_count = 0;
	int          items_sent = 0;
	int          status_seen [5];
	int          burst_left = 0;

	ip_range_table_lookup_top #(
		.TABLE_ENTRIES(DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.range_start(range_start),
		.range_end  (range_end),
		.lookup_key (lookup_key),
		.done       (done),
		.status     (status),
		.entry_index(entry_index)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Work out the result of one item and advance the shadow table
	function automatic outcome_t range_table_predict(input logic op_i,
			input logic [31:0] s_i, input logic [31:0] e_i, input logic [31:0] key_i);
		outcome_t res;
		int       best;
		bit       found;
		res.status = ipr_pkg::ST_MISS;
		res.index  = '0;
		best       = 0;
		found      = 1'b0;
		if (op_i == ipr_pkg::OP_INSERT) begin
			res.status = ipr_pkg::ST_INSERTED;
			for (int i = 0; i < tbl_count; i++) begin
				if (tbl_start[i] == s_i)
					res.status = ipr_pkg::ST_DUPLICATE;
			end
			if (res.status == ipr_pkg::ST_INSERTED) begin
				if (tbl_count >= DEPTH) begin
					res.status = ipr_pkg::ST_FULL;
				end else begin
					tbl_start[tbl_count] = s_i;
					tbl_end[tbl_count]   = e_i;
					res.index            = 8'(tbl_count);
					tbl_count++;
				end
			end
		end else begin
			// greatest start not above the key wins
			for (int i = 0; i < tbl_count; i++) begin
				if (tbl_start[i] <= key_i && (!found || tbl_start[i] > tbl_start[best])) begin
					best  = i;
					found = 1'b1;
				end
			end
			if (found && key_i <= tbl_end[best]) begin
				res.status = ipr_pkg::ST_HIT;
				res.index  = 8'(best);
			end
		end
		return res;
	endfunction

	// Drive one item, hold it until the transfer, then idle between bursts
	task automatic send_item(input logic op_i, input logic [31:0] s_i,
			input logic [31:0] e_i, input logic [31:0] key_i);
		int gap;
		op          <= op_i;
		range_start <= s_i;
		range_end   <= e_i;
		lookup_key  <= key_i;
		start       <= 1'b1;
		do @(posedge clk); while (busy);
		pending_results.push_back(range_table_predict(op_i, s_i, e_i, key_i));
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			case ($urandom_range(0, 2))
				0: gap = $urandom_range(1, 4);
				1: gap = $urandom_range(0, tbl_count + 6);
				default: gap = 0;
			endcase
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 24);
		end
	endtask

	task automatic insert_range(input logic [31:0] s_i, input logic [31:0] e_i);
		send_item(ipr_pkg::OP_INSERT, s_i, e_i, $urandom);
	endtask

	task automatic lookup_addr(input logic [31:0] key_i);
		send_item(ipr_pkg::OP_LOOKUP, $urandom, $urandom, key_i);
	endtask

	// End address a given span above the start, clipped at the top of the space
	function automatic logic [31:0] clip_end(input logic [31:0] s_i, input int unsigned span);
		if (s_i > 32'hFFFF_FFFF - span)
			return 32'hFFFF_FFFF;
		return s_i + span;
	endfunction

	// Choose a key near a stored boundary most of the time
	function automatic logic [31:0] pick_key();
		int idx;
		if (tbl_count == 0)
			return $urandom;
		idx = $urandom_range(0, tbl_count - 1);
		case ($urandom_range(0, 5))
			0: return tbl_start[idx];
			1: return tbl_end[idx];
			2: return tbl_end[idx] + 32'd1;
			3: return tbl_start[idx] - 32'd1;
			4: return clip_end(tbl_start[idx], $urandom_range(0, 4095));
			default: return $urandom;
		endcase
	endfunction

	// Random range: mostly well formed, some inverted, duplicate or overlapping
	task automatic insert_random_range();
		logic [31:0] s;
		logic [31:0] e;
		int          idx;
		s = $urandom;
		e = clip_end(s, $urandom_range(0, 4095));
		idx = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
		case ($urandom_range(0, 9))
			0: begin
				e = $urandom;
				if (e >= s && s != 0)
					e = s - 32'd1;
			end
			1: if (tbl_count > 0) s = tbl_start[idx];
			2: if (tbl_count > 0) begin
				s = tbl_start[idx] + $urandom_range(1, 64);
				e = clip_end(s, $urandom_range(0, 8191));
			end
			default: ;
		endcase
		insert_range(s, e);
	endtask

	task automatic test_empty_table();
		lookup_addr(32'h0000_0000);
		lookup_addr(32'hFFFF_FFFF);
		insert_range(32'h8000_0000, 32'h8000_FFFF);
		// key below every stored start
		lookup_addr(32'h7FFF_FFFF);
		lookup_addr(32'h0000_0000);
	endtask

	task automatic test_insert_cases();
		insert_range(32'h0000_0000, 32'h0000_0000);
		insert_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// same start again, different end
		insert_range(32'h0000_0000, 32'h1234_5678);
		insert_range(32'h8000_0000, 32'hFFFF_FFFF);
		// inverted range is stored as given
		insert_range(32'h4000_0000, 32'h3FFF_FFFF);
		insert_range(32'h5555_5555, 32'hAAAA_AAAA);
	endtask

	task automatic test_lookup_cases();
		lookup_addr(32'h0000_0000);
		lookup_addr(32'h0000_0001);
		lookup_addr(32'hFFFF_FFFF);
		lookup_addr(32'h8000_0000);
		lookup_addr(32'h8000_FFFF);
		lookup_addr(32'h8001_0000);
		lookup_addr(32'h4000_0000);
		lookup_addr(32'h4000_0001);
		lookup_addr(32'h5555_5555);
		lookup_addr(32'hAAAA_AAAA);
		lookup_addr(32'hAAAA_AAAB);
	endtask

	// Grow the table to its last entry with lookups mixed in
	task automatic test_random_fill();
		while (tbl_count < DEPTH) begin
			if ($urandom_range(0, 99) < 55)
				insert_random_range();
			else
				lookup_addr(pick_key());
		end
	endtask

	// Full table: new starts are refused, known starts still report duplicate
	task automatic test_full_table();
		for (int n = 0; n < FULL_ITEMS; n++) begin
			case ($urandom_range(0, 9))
				0: insert_range($urandom, $urandom);
				1: insert_range(tbl_start[$urandom_range(0, DEPTH - 1)], $urandom);
				default: lookup_addr(pick_key());
			endcase
		end
	endtask

	// Compare each result strobe with the oldest prediction
	always @(posedge clk) begin
		outcome_t exp_res;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d entry_index %0d", status, entry_index);
				err_count++;
			end else begin
				exp_res = pending_results.pop_front();
				status_seen[exp_res.status]++;
				if (status !== exp_res.status) begin
					$error("status: expected %0d, got %0d", exp_res.status, status);
					err_count++;
				end
				if (entry_index !== exp_res.index) begin
					$error("entry_index: expected %0d, got %0d", exp_res.index, entry_index);
					err_count++;
				end
			end
		end
	end

	// End the run when nothing has moved for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (arst_n && ((start && !busy) || done))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_insert_cases();
		test_lookup_cases();
		test_random_fill();
		test_full_table();

		// release the command channel and drain
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		$display("Sent %0d items, table filled to %0d entries.", items_sent, tbl_count);
		$display("Results: %0d inserted, %0d duplicate, %0d full, %0d hit, %0d miss.",
			status_seen[ipr_pkg::ST_INSERTED], status_seen[ipr_pkg::ST_DUPLICATE],
			status_seen[ipr_pkg::ST_FULL], status_seen[ipr_pkg::ST_HIT],
			status_seen[ipr_pkg::ST_MISS]);
		if (err_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
